FILE: src/lzsswd_pkg.sv
// Package with the shared constants of the LZSS window decoder.
package lzsswd_pkg;

  // Byte width of the compressed and decompressed streams.
  localparam int unsigned ByteW = 8;

  // Ring window geometry.
  localparam int unsigned WinSize = 4096;
  localparam int unsigned WinAw = $clog2(WinSize);
  localparam int unsigned LookAhead = 18;
  localparam int unsigned MinMatch = 2;

  // First ring position that receives output.
  localparam logic [WinAw-1:0] WposReset = WinAw'(WinSize - LookAhead);

  // Width of the output byte counter.
  localparam int unsigned CountW = 32;

  // Width of a copy length (up to LookAhead).
  localparam int unsigned LenW = $clog2(LookAhead + 1);

endpackage

FILE: src/lzsswd_if.sv
// Request channels for compressed input bytes and decompressed output bytes.
interface lzsswd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lzsswd_pkg::ByteW-1:0]  in_byte;
  logic                          frame_start;
  logic                          input_last;

  modport source (output valid, in_byte, frame_start, input_last, input ready);
  modport sink   (input valid, in_byte, frame_start, input_last, output ready);
endinterface

interface lzsswd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lzsswd_pkg::ByteW-1:0]  out_byte;
  logic                          run_last;
  logic                          stream_done;

  modport source (output valid, out_byte, run_last, stream_done, input ready);
  modport sink   (input valid, out_byte, run_last, stream_done, output ready);
endinterface

FILE: src/lzsswd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lzsswd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/lzss_window_decoder.sv
// Top level of the LZSS decoder with a 4096-byte ring window.
//
//   channel | dir | payload                               | accepted when
//   in_if   | in  | in_byte, frame_start, input_last      | valid & ready
//   out_if  | out | out_byte, run_last, stream_done       | valid & ready
//
// Header, flag and reference-low bytes are taken while idle; a literal is
// emitted at once when the output register is free. A reference blocks input
// while its copy runs through the window RAM read port, one byte per cycle
// while the output register is free. Stalls pause it without losing data.
// No clearing pass: a fill count marks which ring entries hold frame data, and
// entries outside it read as zero, so the block is ready right after reset.
module lzss_window_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  lzsswd_in_if.sink          in_if,
  lzsswd_out_if.source       out_if
);
  import lzsswd_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StLit,
    StCopy
  } state_e;

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhHdr2,
    PhHdr3,
    PhFlag,
    PhToken,
    PhRef2,
    PhDone
  } phase_e;

  state_e               state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     flags_q, flags_d;
  logic [2:0]           fidx_q, fidx_d;
  logic [ByteW-1:0]     offlo_q, offlo_d;
  logic [CountW-1:0]    remain_q, remain_d;
  logic [WinAw-1:0]     wpos_q, wpos_d;
  logic [WinAw:0]       fill_q, fill_d;
  logic [ByteW-1:0]     lit_q, lit_d;
  logic [WinAw-1:0]     raddr_q, raddr_d;
  logic [LenW-1:0]      left_q, left_d;
  logic                 pend_q, pend_d;
  logic                 fwd_q, fwd_d;
  logic                 rvalid_q, rvalid_d;
  logic [ByteW-1:0]     fwd_byte_q, fwd_byte_d;
  logic                 ovalid_q, ovalid_d;
  logic [ByteW-1:0]     obyte_q, obyte_d;
  logic                 olast_q, olast_d;
  logic                 odone_q, odone_d;

  logic                 in_fire;
  logic                 slot_free;
  logic                 emit_valid;
  logic [ByteW-1:0]     emit_byte;
  logic                 emit_last;
  logic                 emit_done;
  logic                 issue;
  logic [ByteW-1:0]     rdata;
  phase_e               phase_eff;
  logic [2:0]           fidx_next;
  phase_e               phase_next_tok;
  logic [LenW-1:0]      ref_len;
  logic                 ref_reach;
  logic [WinAw-1:0]     fill_diff;
  logic                 lit_now;

  // Window RAM: one write per emitted byte, one read per copied byte.
  lzsswd_ram #(
    .Width (ByteW),
    .Depth (WinSize)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (emit_valid),
    .waddr_i (wpos_q),
    .wdata_i (emit_byte),
    .re_i    (issue),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  // Handshakes.
  assign in_if.ready = (state_q == StIdle);
  assign in_fire     = in_if.valid && in_if.ready;
  assign slot_free   = !ovalid_q || out_if.ready;

  // Parser decode helpers.
  assign phase_eff      = in_if.frame_start ? PhHdr0 : phase_q;
  assign fidx_next      = fidx_q + 3'd1;
  assign phase_next_tok = (fidx_next == 3'd0) ? PhFlag : PhToken;
  assign lit_now        = in_fire && (phase_eff == PhToken) && flags_q[fidx_q];
  assign ref_len        = LenW'({1'b0, in_if.in_byte[3:0]}) + LenW'(MinMatch + 1);
  assign ref_reach      = (remain_q <= CountW'(ref_len));
  assign emit_done      = (remain_q == CountW'(1));

  // Copy read issue: a new read only when no byte is pending or the pending byte leaves this cycle.
  assign issue = (state_q == StCopy) && (left_q != '0) && (!pend_q || slot_free);

  // Ring entries written since frame start lie from WposReset over the next fill_q positions.
  assign fill_diff = raddr_q - WposReset;

  // Byte emission for the output register and the window write.
  always_comb begin
    emit_valid = 1'b0;
    emit_byte  = '0;
    emit_last  = 1'b0;
    case (state_q)
      StIdle: begin
        if (lit_now && slot_free) begin
          emit_valid = 1'b1;
          emit_byte  = in_if.in_byte;
          emit_last  = 1'b1;
        end
      end
      StLit: begin
        if (slot_free) begin
          emit_valid = 1'b1;
          emit_byte  = lit_q;
          emit_last  = 1'b1;
        end
      end
      StCopy: begin
        if (pend_q && slot_free) begin
          emit_valid = 1'b1;
          emit_byte  = fwd_q ? fwd_byte_q : (rvalid_q ? rdata : '0);
          emit_last  = (left_q == '0);
        end
      end
      default: ;
    endcase
  end

  // Next-state logic for parser, copy engine and output register.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    flags_d    = flags_q;
    fidx_d     = fidx_q;
    offlo_d    = offlo_q;
    remain_d   = remain_q;
    wpos_d     = wpos_q;
    fill_d     = fill_q;
    lit_d      = lit_q;
    raddr_d    = raddr_q;
    left_d     = left_q;
    pend_d     = pend_q;
    fwd_d      = fwd_q;
    rvalid_d   = rvalid_q;
    fwd_byte_d = fwd_byte_q;
    ovalid_d   = ovalid_q;
    obyte_d    = obyte_q;
    olast_d    = olast_q;
    odone_d    = odone_q;

    // Effects of an emitted byte on the ring and the count.
    if (emit_valid) begin
      wpos_d     = wpos_q + WinAw'(1);
      fill_d     = fill_q[WinAw] ? fill_q : fill_q + (WinAw+1)'(1);
      remain_d   = remain_q - CountW'(1);
      fwd_byte_d = emit_byte;
    end

    // Output register.
    if (emit_valid) begin
      ovalid_d = 1'b1;
      obyte_d  = emit_byte;
      olast_d  = emit_last;
      odone_d  = emit_done;
    end else if (out_if.ready) begin
      ovalid_d = 1'b0;
    end

    // Accepted compressed byte.
    if (in_fire) begin
      if (in_if.frame_start) begin
        flags_d  = '0;
        fidx_d   = '0;
        offlo_d  = '0;
        remain_d = '0;
        wpos_d   = WposReset;
        fill_d   = '0;
      end
      case (phase_eff)
        PhHdr0, PhHdr1, PhHdr2, PhHdr3: begin
          remain_d = in_if.frame_start ? '0 : remain_q;
          remain_d[{phase_eff[1:0], 3'b000} +: ByteW] = in_if.in_byte;
          phase_d = phase_e'(phase_eff + 3'd1);
          if ((phase_eff == PhHdr3) && (remain_d == '0)) begin
            phase_d = PhDone;
          end
        end
        PhFlag: begin
          flags_d = in_if.in_byte;
          fidx_d  = '0;
          phase_d = PhToken;
        end
        PhToken: begin
          if (flags_q[fidx_q]) begin
            if (emit_done) begin
              phase_d = PhDone;
            end else begin
              fidx_d  = fidx_next;
              phase_d = phase_next_tok;
            end
            if (!slot_free) begin
              lit_d   = in_if.in_byte;
              state_d = StLit;
            end
          end else begin
            offlo_d = in_if.in_byte;
            phase_d = PhRef2;
          end
        end
        PhRef2: begin
          raddr_d = {in_if.in_byte[7:4], offlo_q};
          left_d  = ref_reach ? remain_q[LenW-1:0] : ref_len;
          pend_d  = 1'b0;
          state_d = StCopy;
          if (ref_reach) begin
            phase_d = PhDone;
          end else begin
            fidx_d  = fidx_next;
            phase_d = phase_next_tok;
          end
        end
        default: ;
      endcase
      if (in_if.input_last) begin
        phase_d = PhDone;
      end
    end

    // Literal waiting for the output register.
    if ((state_q == StLit) && emit_valid) begin
      state_d = StIdle;
    end

    // Copy engine: read, then emit and write back the read, forwarded or zero byte once the output register is free.
    if (state_q == StCopy) begin
      if (issue) begin
        raddr_d  = raddr_q + WinAw'(1);
        left_d   = left_q - LenW'(1);
        pend_d   = 1'b1;
        fwd_d    = emit_valid && (raddr_q == wpos_q);
        rvalid_d = fill_q[WinAw] || ({1'b0, fill_diff} < fill_q);
      end else if (emit_valid) begin
        pend_d = 1'b0;
      end
      if (emit_valid && (left_q == '0)) begin
        state_d = StIdle;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      phase_q    <= PhHdr0;
      flags_q    <= '0;
      fidx_q     <= '0;
      offlo_q    <= '0;
      remain_q   <= '0;
      wpos_q     <= WposReset;
      fill_q     <= '0;
      lit_q      <= '0;
      raddr_q    <= '0;
      left_q     <= '0;
      pend_q     <= 1'b0;
      fwd_q      <= 1'b0;
      rvalid_q   <= 1'b0;
      fwd_byte_q <= '0;
      ovalid_q   <= 1'b0;
      obyte_q    <= '0;
      olast_q    <= 1'b0;
      odone_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      flags_q    <= flags_d;
      fidx_q     <= fidx_d;
      offlo_q    <= offlo_d;
      remain_q   <= remain_d;
      wpos_q     <= wpos_d;
      fill_q     <= fill_d;
      lit_q      <= lit_d;
      raddr_q    <= raddr_d;
      left_q     <= left_d;
      pend_q     <= pend_d;
      fwd_q      <= fwd_d;
      rvalid_q   <= rvalid_d;
      fwd_byte_q <= fwd_byte_d;
      ovalid_q   <= ovalid_d;
      obyte_q    <= obyte_d;
      olast_q    <= olast_d;
      odone_q    <= odone_d;
    end
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.out_byte    = obyte_q;
  assign out_if.run_last    = olast_q;
  assign out_if.stream_done = odone_q;

`ifndef SYNTHESIS
  // A byte is emitted only into a free output register.
  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_valid |-> slot_free)
    else $error("byte emitted while output register is occupied");

  // The fill count never exceeds the window size.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (WinAw+1)'(WinSize))
    else $error("window fill count out of range");

  // Once every read is issued, the copy still holds its final byte.
  a_copy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCopy) && (left_q == '0)) |-> pend_q)
    else $error("copy engine lost its final byte");

  // The byte that reaches the stated count ends the frame.
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid && emit_done) |=> (phase_q == PhDone))
    else $error("frame not done after reaching the stated count");
`endif

endmodule

FILE: tb/sv/lzss_window_decoder_test.sv
// Self-checking testbench for the LZSS window decoder: directed frames, then random streams.
module lzss_window_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lzsswd_pkg::*;

  // Parser phases of the decoder, in the order the stream visits them.
  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_FLAG, PH_TOKEN, PH_REF2, PH_DONE
  } parse_phase_e;

  // One decompressed byte as the output channel presents it.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             run_end;
    logic             done;
  } out_beat_t;

  logic clk;
  logic rst_n;

  lzsswd_in_if  in_ch ();
  lzsswd_out_if out_ch ();

  lzss_window_decoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Decoder state as predicted by the testbench.
  logic [ByteW-1:0]  ring_mem [WinSize];
  logic [WinAw-1:0]  ring_wr;
  logic [ByteW-1:0]  flag_reg;
  logic [2:0]        flag_idx;
  parse_phase_e      phase;
  logic [ByteW-1:0]  ofs_lo;
  logic [CountW-1:0] want_count;
  logic [CountW-1:0] made_count;

  out_beat_t   decoded_q [$];
  int unsigned mismatches;
  int unsigned burst_left;

  // Receiver stall pattern state.
  int unsigned rx_mode;
  int unsigned rx_hold;
  int unsigned rx_cycle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Frame start: clear the window and the parser.
  task automatic clear_window();
    for (int i = 0; i < WinSize; i++) begin
      ring_mem[i] = '0;
    end
    ring_wr    = WposReset;
    flag_reg   = '0;
    flag_idx   = '0;
    phase      = PH_HDR0;
    ofs_lo     = '0;
    want_count = '0;
    made_count = '0;
  endtask

  // Write one output byte to the ring and queue it; returns 1 at the stated count.
  function automatic bit emit_byte(input logic [ByteW-1:0] b);
    out_beat_t beat;
    ring_mem[ring_wr] = b;
    ring_wr    = ring_wr + 1'b1;
    made_count = made_count + 1'b1;
    beat.data    = b;
    beat.run_end = 1'b0;
    beat.done    = (made_count == want_count);
    decoded_q.push_back(beat);
    return beat.done;
  endfunction

  function automatic void advance_token();
    flag_idx = flag_idx + 1'b1;
    phase    = (flag_idx == '0) ? PH_FLAG : PH_TOKEN;
  endfunction

  // Predict the output bytes caused by one accepted compressed byte.
  task automatic predict_byte(input logic [ByteW-1:0] b, input logic start, input logic is_last);
    int unsigned      n_out;
    int unsigned      run_len;
    logic [WinAw-1:0] src;
    bit               reached;
    n_out   = 0;
    reached = 1'b0;
    if (start) begin
      clear_window();
    end
    case (phase)
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3: begin
        want_count = want_count | (CountW'(b) << (8 * int'(phase)));
        phase = parse_phase_e'(phase + 1'b1);
        if (phase == PH_FLAG && want_count == '0) begin
          phase = PH_DONE;
        end
      end
      PH_FLAG: begin
        flag_reg = b;
        flag_idx = '0;
        phase    = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (flag_reg[flag_idx]) begin
          reached = emit_byte(b);
          n_out++;
          if (reached) begin
            phase = PH_DONE;
          end else begin
            advance_token();
          end
        end else begin
          ofs_lo = b;
          phase  = PH_REF2;
        end
      end
      PH_REF2: begin
        // Copy one byte at a time so an overlapping copy sees its own output.
        src     = {b[7:4], ofs_lo};
        run_len = int'(b[3:0]) + MinMatch + 1;
        for (int k = 0; k < run_len && !reached; k++) begin
          reached = emit_byte(ring_mem[src + WinAw'(k)]);
          n_out++;
        end
        if (reached) begin
          phase = PH_DONE;
        end else begin
          advance_token();
        end
      end
      default: begin
      end
    endcase
    if (is_last) begin
      phase = PH_DONE;
    end
    if (n_out > 0) begin
      decoded_q[decoded_q.size() - 1].run_end = 1'b1;
    end
  endtask

  // Prediction on each accepted request, then comparison of each accepted result.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.in_byte, in_ch.frame_start, in_ch.input_last);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h", out_ch.out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, wanted %02h", out_ch.out_byte, want.data));
          end
          if (out_ch.run_last !== want.run_end) begin
            report_mismatch($sformatf("run_last %b, wanted %b", out_ch.run_last, want.run_end));
          end
          if (out_ch.stream_done !== want.done) begin
            report_mismatch($sformatf("stream_done %b, wanted %b", out_ch.stream_done,
                                      want.done));
          end
        end
      end
    end
  end

  // Receiver: stalls follow one of four randomly chosen patterns.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (rx_cycle % 4 == 0);
        default: begin
          if (rx_hold > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold--;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
              rx_hold = $urandom_range(3, 12);
            end
          end
        end
      endcase
    end
  end

  // Send one compressed byte; the sender idles between bursts of random length.
  task automatic send_byte(input logic [ByteW-1:0] data, input logic start, input logic is_last);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 16);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= data;
    in_ch.frame_start <= start;
    in_ch.input_last  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Hold the sender off until every predicted byte has come out and the block is idle.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Two literals at the byte extremes, then a full-length copy overlapping its source.
  task automatic test_overlap_copy();
    send_byte(8'd20, 1'b1, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hEE, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // The frame is done, so this byte must be ignored.
    send_byte(8'h5A, 1'b0, 1'b1);
    hold_until_drained();
  endtask

  // A zero count finishes the frame right after the header.
  task automatic test_zero_count();
    send_byte(8'd0, 1'b1, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    hold_until_drained();
  endtask

  // Shortest copy from the top offset, then a longest copy cut at the stated count.
  task automatic test_copy_cut();
    send_byte(8'd5, 1'b1, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h0F, 1'b0, 1'b0);
    hold_until_drained();
  endtask

  // The last byte arrives inside the header.
  task automatic test_header_cut();
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1);
    hold_until_drained();
  endtask

  // The last byte arrives in the middle of a reference, which is then dropped.
  task automatic test_dropped_token();
    send_byte(8'd3, 1'b1, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b0);
    send_byte(8'h10, 1'b0, 1'b1);
    hold_until_drained();
  endtask

  // Well-formed frame with random tokens; cut_at > 0 abandons it early.
  task automatic send_frame(input int unsigned count, input int unsigned cut_at,
                            output int unsigned sent);
    int unsigned      left;
    int unsigned      run;
    logic [WinAw-1:0] pos;
    logic [WinAw-1:0] off;
    logic [7:0]       flags;
    logic [3:0]       len_code;
    bit               mark_end;
    left     = count;
    pos      = WposReset;
    sent     = 0;
    mark_end = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < 4; i++) begin
      send_byte(8'(count >> (8 * i)), i == 0, 1'b0);
      sent++;
    end
    while (left > 0 && (cut_at == 0 || sent < cut_at)) begin
      flags = 8'($urandom);
      send_byte(flags, 1'b0, 1'b0);
      sent++;
      for (int t = 0; t < 8 && left > 0; t++) begin
        if (flags[t]) begin
          send_byte(8'($urandom), 1'b0, mark_end && left == 1);
          left--;
          pos++;
          sent++;
        end else begin
          // Mostly near references, which often overlap the bytes being written.
          len_code = 4'($urandom);
          run      = int'(len_code) + MinMatch + 1;
          off      = ($urandom_range(0, 3) != 0) ? pos - WinAw'($urandom_range(1, 24))
                                                 : WinAw'($urandom);
          send_byte(off[7:0], 1'b0, 1'b0);
          send_byte({off[11:8], len_code}, 1'b0, mark_end && run >= left);
          sent += 2;
          pos  += WinAw'((run >= left) ? left : run);
          left  = (run >= left) ? 0 : left - run;
        end
      end
    end
    // A byte after the frame is done must be ignored.
    if (!mark_end && cut_at == 0 && $urandom_range(0, 2) == 0) begin
      send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  // Random bytes from the header on, with stray starts and ends.
  task automatic send_noise(output int unsigned sent);
    int unsigned total;
    bit          start_it;
    bit          end_it;
    total    = 4 + $urandom_range(1, 30);
    start_it = ($urandom_range(0, 3) != 0);
    end_it   = ($urandom_range(0, 1) == 0);
    for (int i = 0; i < total; i++) begin
      send_byte(8'($urandom), i == 0 && start_it,
                (i == total - 1 && end_it) || $urandom_range(0, 39) == 0);
    end
    sent = total;
  endtask

  // Mostly well-formed frames, some abandoned, some pure noise.
  task automatic test_random_stream();
    int unsigned sent_total;
    int unsigned n;
    int unsigned frames;
    int unsigned pick;
    sent_total = 0;
    frames     = 0;
    while (sent_total < 300) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                               : $urandom_range(1, 40), 0, n);
      end else if (pick == 7) begin
        send_frame($urandom_range(20, 200), $urandom_range(6, 20), n);
      end else begin
        send_noise(n);
      end
      sent_total += n;
      frames++;
      if (frames % 12 == 0) begin
        hold_until_drained();
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= '0;
    in_ch.frame_start <= 1'b0;
    in_ch.input_last  <= 1'b0;
    mismatches = 0;
    burst_left = 0;
    rx_mode    = 0;
    rx_hold    = 0;
    rx_cycle   = 0;
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_overlap_copy();
    test_zero_count();
    test_copy_cut();
    test_header_cut();
    test_dropped_token();
    test_random_stream();

    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
